// ----- hw/rtl/sms_pkg.sv -----
// ============================================================================
// Shoreline marking stencil package
// Shared widths, codes, result record and the water test.
// ============================================================================
package sms_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int HEIGHT_LIMIT   = 4096;

    localparam int TILE_W         = 8;
    localparam int OUT_COL_W      = 8;
    localparam int OUT_ROW_W      = 12;
    localparam int IN_ROW_W       = 13;
    localparam int PAIR_W         = 2 * TILE_W;
    localparam int WIN_W          = 9;

    localparam int CFG_WIDTH_W    = 9;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam int CFG_WIDTH_RST  = 256;
    localparam int CFG_HEIGHT_RST = 256;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    // Item kinds.
    localparam logic OP_TILE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [4:0]        TYPE_WATER_A = 5'h01;
    localparam logic [4:0]        TYPE_WATER_B = 5'h04;
    localparam logic [4:0]        TYPE_WATER_C = 5'h16;
    localparam logic [TILE_W-1:0] SHORE_CODE   = 8'h02;

    // Window bit groups: bits 0..2 left column, 3..5 center, 6..8 right,
    // each column ordered top, middle, bottom.
    localparam logic [WIN_W-1:0] MASK_BASE   = 9'h1ef;
    localparam logic [WIN_W-1:0] MASK_LEFT   = 9'h007;
    localparam logic [WIN_W-1:0] MASK_RIGHT  = 9'h1c0;
    localparam logic [WIN_W-1:0] MASK_TOP    = 9'h049;
    localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;

    typedef struct packed {
        logic                 emit;
        logic [TILE_W-1:0]    tile;
        logic [OUT_COL_W-1:0] column;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_result;

    function automatic logic is_water(input logic [TILE_W-1:0] code);
        logic [4:0] kind;
        kind = code[4:0];
        return (kind == TYPE_WATER_A) || (kind == TYPE_WATER_B) ||
               (kind == TYPE_WATER_C);
    endfunction

endpackage

// ----- hw/rtl/sms_line_buffer.sv -----
// ============================================================================
// Line buffer
// Two stacked map rows in one memory, registered read, write bypass.
// ============================================================================
module sms_line_buffer #(
    parameter int DEPTH = sms_pkg::DEF_MAX_WIDTH,
    parameter int DW    = sms_pkg::PAIR_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    import sms_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] r_byp_data;
    logic          r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // A read that collides with a write in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;

endmodule

// ----- hw/rtl/sms_stencil.sv -----
// ============================================================================
// Stencil core
// Raster counters, 3x3 water window and shore decision for one item.
// ============================================================================
module sms_stencil #(
    parameter int MAX_WIDTH = sms_pkg::DEF_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [COL_W-1:0]              i_w_m1,
    input  logic [sms_pkg::OUT_ROW_W-1:0] i_h_m1,
    input  logic                          i_step,
    input  logic                          i_opcode,
    input  logic [sms_pkg::TILE_W-1:0]    i_tile_code,
    input  logic [sms_pkg::PAIR_W-1:0]    i_rd_data,
    output logic [COL_W-1:0]              o_rd_addr,
    output logic                          o_wr_en,
    output logic [COL_W-1:0]              o_wr_addr,
    output logic [sms_pkg::PAIR_W-1:0]    o_wr_data,
    output sms_pkg::t_result              o_res
);
    import sms_pkg::*;

    logic [COL_W-1:0]     r_in_col,  n_in_col;
    logic [IN_ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]     r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;
    logic [WIN_W-1:0]     r_flags,   n_flags;
    logic [TILE_W-1:0]    r_pipe0,   n_pipe0;

    logic                 in_map;
    logic                 ignore;
    logic [TILE_W-1:0]    tile;
    logic [TILE_W-1:0]    upper;
    logic [TILE_W-1:0]    middle;
    logic [WIN_W-1:0]     flags_nx;
    logic [WIN_W-1:0]     mask;
    logic                 emit;
    logic                 shore;
    logic                 last;
    logic                 advance;

    always_comb begin
        in_map   = r_in_row <= {1'b0, i_h_m1};
        ignore   = (i_opcode == OP_DRAIN) && in_map;
        tile     = ((i_opcode == OP_TILE) && in_map) ? i_tile_code : '0;
        upper    = i_rd_data[PAIR_W-1:TILE_W];
        middle   = i_rd_data[TILE_W-1:0];
        flags_nx = {is_water(tile), is_water(middle), is_water(upper), r_flags[WIN_W-1:3]};
        emit     = (r_in_row >= IN_ROW_W'(2)) ||
                   ((r_in_row == IN_ROW_W'(1)) && (r_in_col != '0));

        // Neighbors outside the map do not count.
        mask = MASK_BASE;
        if (r_out_col == '0) begin
            mask = mask & ~MASK_LEFT;
        end
        if (r_out_col >= i_w_m1) begin
            mask = mask & ~MASK_RIGHT;
        end
        if (r_out_row == '0) begin
            mask = mask & ~MASK_TOP;
        end
        if (r_out_row >= i_h_m1) begin
            mask = mask & ~MASK_BOTTOM;
        end

        // The center tile of the window is the middle byte read one step ago.
        shore = !is_water(r_pipe0) && ((flags_nx & mask) != '0);
        last  = (r_out_row > i_h_m1) ||
                ((r_out_row == i_h_m1) && (r_out_col >= i_w_m1));
        advance = i_step && !ignore;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_flags   = r_flags;
        n_pipe0   = r_pipe0;
        if (advance) begin
            n_pipe0 = middle;
            n_flags = flags_nx;
            if (r_in_col >= i_w_m1) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (last) begin
                    // End of map: start the next one from a clean window.
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_flags   = '0;
                    n_pipe0   = '0;
                end else if (r_out_col >= i_w_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_flags   <= '0;
            r_pipe0   <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_flags   <= n_flags;
            r_pipe0   <= n_pipe0;
        end
    end

    assign o_rd_addr = n_in_col;
    assign o_wr_en   = advance;
    assign o_wr_addr = r_in_col;
    assign o_wr_data = {middle, tile};

    assign o_res.emit   = emit && !ignore;
    assign o_res.tile   = shore ? SHORE_CODE : r_pipe0;
    assign o_res.column = OUT_COL_W'(r_out_col);
    assign o_res.row    = r_out_row;
    assign o_res.last   = last;

endmodule

// ----- hw/rtl/shoreline_marking_stencil.sv -----
// ============================================================================
// Shoreline marking stencil
// Marks land tiles that touch water as shore in a raster tile stream.
// ============================================================================
// Usage:
// Tiles enter on the input channel (i_in_valid / o_in_stall) in raster order,
// one transaction per tile, opcode tile. Each tile leaves on the output
// channel (o_out_valid / i_out_stall) one map row plus one tile later in the
// stream, with its column, row and a frame_last flag on the final tile. A land
// tile with water among its neighbors inside the map comes out as the shore
// code; every other tile comes out unchanged. After the last tile of a map,
// width + 1 drain transactions (or tiles of the next map) push the final row
// out. A drain while the map still expects tiles is dropped.
// Throughput is one transaction per cycle on each side. A transaction is held
// in the input register while the line buffer read completes; the result it
// releases is then written to the output register. When the receiver stalls,
// the output register holds its transaction. Once the input register holds a
// transaction that would release a result, o_in_stall follows i_out_stall in
// the same cycle while the output register is full; transactions that release
// nothing still pass through.
// Synchronous reset clears the counters, window and both valid flags, sets the
// map to 256 x 256 and needs no line buffer clearing pass. The user must write
// map width and height via the configuration port only while idle; unenforced.
// ============================================================================
module shoreline_marking_stencil #(
    parameter int MAX_WIDTH = sms_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [sms_pkg::TILE_W-1:0]      i_tile_code,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sms_pkg::TILE_W-1:0]      o_tile_out,
    output logic [sms_pkg::OUT_COL_W-1:0]   o_out_column,
    output logic [sms_pkg::OUT_ROW_W-1:0]   o_out_row,
    output logic                            o_frame_last,
    input  logic                            i_cfg_we,
    input  logic [sms_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sms_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RST_WIDTH = (CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RST;
    localparam logic [COL_W-1:0]     RST_W_M1 = COL_W'(RST_WIDTH - 1);
    localparam logic [OUT_ROW_W-1:0] RST_H_M1 = OUT_ROW_W'(CFG_HEIGHT_RST - 1);

    // Map size is kept as last column and last row, already clamped.
    logic [COL_W-1:0]        r_w_m1, n_w_m1;
    logic [OUT_ROW_W-1:0]    r_h_m1, n_h_m1;
    logic [CFG_WIDTH_W-1:0]  cfg_w;
    logic [CFG_HEIGHT_W-1:0] cfg_h;

    logic                    r_s1_valid;
    logic                    r_s1_opcode;
    logic [TILE_W-1:0]       r_s1_tile;

    logic                    r_out_valid;
    t_result                 r_out;

    logic                    in_accept;
    logic                    s1_go;

    logic [COL_W-1:0]        rd_addr;
    logic [PAIR_W-1:0]       rd_data;
    logic                    wr_en;
    logic [COL_W-1:0]        wr_addr;
    logic [PAIR_W-1:0]       wr_data;
    t_result                 res;

    // ------------------------------------------------------------------
    // Configuration registers, clamped on write.
    // ------------------------------------------------------------------
    always_comb begin
        cfg_w  = i_cfg_data[CFG_WIDTH_W-1:0];
        cfg_h  = i_cfg_data[CFG_HEIGHT_W-1:0];
        n_w_m1 = r_w_m1;
        n_h_m1 = r_h_m1;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH: begin
                    if (cfg_w == '0) begin
                        n_w_m1 = '0;
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        n_w_m1 = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        n_w_m1 = COL_W'(cfg_w - CFG_WIDTH_W'(1));
                    end
                end
                CFG_MAP_HEIGHT: begin
                    if (cfg_h == '0) begin
                        n_h_m1 = '0;
                    end else if (32'(cfg_h) > HEIGHT_LIMIT) begin
                        n_h_m1 = OUT_ROW_W'(HEIGHT_LIMIT - 1);
                    end else begin
                        n_h_m1 = OUT_ROW_W'(cfg_h - CFG_HEIGHT_W'(1));
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= RST_W_M1;
            r_h_m1 <= RST_H_M1;
        end else begin
            r_w_m1 <= n_w_m1;
            r_h_m1 <= n_h_m1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The stencil step runs when its result, if any, has room
    // in the output register.
    // ------------------------------------------------------------------
    assign s1_go      = r_s1_valid && (!res.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_opcode <= i_opcode;
            r_s1_tile   <= i_tile_code;
        end
    end

    // The line buffer is read at the column this transaction will use,
    // which already accounts for the step running in the same cycle.
    sms_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .DW    (PAIR_W)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sms_stencil #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stencil (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w_m1      (r_w_m1),
        .i_h_m1      (r_h_m1),
        .i_step      (s1_go),
        .i_opcode    (r_s1_opcode),
        .i_tile_code (r_s1_tile),
        .i_rd_data   (rd_data),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res       (res)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res.emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_out   = r_out.tile;
    assign o_out_column = r_out.column;
    assign o_out_row    = r_out.row;
    assign o_frame_last = r_out.last;

endmodule

// ----- hw/rtl/sms_checker.sv -----
// ============================================================================
// Port checker
// Watches the top level's ports for handshake and raster order slips.
// ============================================================================
module sms_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sms_pkg::TILE_W-1:0]    o_tile_out,
    input logic [sms_pkg::OUT_COL_W-1:0] o_out_column,
    input logic [sms_pkg::OUT_ROW_W-1:0] o_out_row,
    input logic                          o_frame_last
);
    import sms_pkg::*;

    logic                 r_seen;
    logic                 r_last;
    logic [OUT_COL_W-1:0] r_col;
    logic [OUT_ROW_W-1:0] r_row;
    logic                 out_take;

    assign out_take = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_take) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_last <= o_frame_last;
            r_col  <= o_out_column;
            r_row  <= o_out_row;
        end
    end

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_tile_out) && $stable(o_out_column) &&
            $stable(o_out_row) && $stable(o_frame_last))
        else $error("stalled output transaction changed");

    a_input_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

    a_raster_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_seen |->
            (r_last && o_out_column == '0 && o_out_row == '0) ||
            (!r_last && o_out_column == OUT_COL_W'(r_col + OUT_COL_W'(1)) &&
                o_out_row == r_row) ||
            (!r_last && o_out_column == '0 &&
                o_out_row == OUT_ROW_W'(r_row + OUT_ROW_W'(1))))
        else $error("output transaction out of raster order");

endmodule

bind shoreline_marking_stencil sms_checker u_sms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_tile_out   (o_tile_out),
    .o_out_column (o_out_column),
    .o_out_row    (o_out_row),
    .o_frame_last (o_frame_last)
);
